FILE: rtl/rrsc_pkg.sv
// rrsc_pkg: shared types, codes and crc-32 helpers for the redundant record block
`timescale 1ns / 1ps

package rrsc_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_CHECK = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SRC_PRIMARY = 2'd0,
      SRC_BACKUP  = 2'd1,
      SRC_NONE    = 2'd2
   } load_src_type;

   typedef enum logic {
      CSR_SAVE_INTERVAL   = 1'b0,
      CSR_DELTA_THRESHOLD = 1'b1
   } csr_idx_type;

   localparam logic [31:0] SAVE_INTERVAL_RST   = 32'd60;
   localparam logic [31:0] DELTA_THRESHOLD_RST = 32'd100;
   localparam logic [31:0] COUNT_MAX           = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY            = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT            = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] energy_sample;
      logic [31:0] primary_energy;
      logic [31:0] primary_check;
      logic [31:0] backup_energy;
      logic [31:0] backup_check;
   } req_word_type;

   typedef struct packed {
      logic        save_now;
      logic [31:0] record_energy;
      logic [31:0] record_crc;
      logic [31:0] write_total;
      logic [31:0] loaded_energy;
      logic [1:0]  load_source;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] save_interval;
      logic [31:0] delta_threshold;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_type;

   typedef logic [31:0][31:0] crc_cols_type;

   // bit-serial reflected crc, lsb first, used only for constants
   function automatic logic [31:0] crc_serial(input logic [31:0] w, input logic [31:0] init);
      logic [31:0] c;
      c = init;
      for (int i = 0; i < 32; i++) begin
         c = c ^ {31'd0, w[i]};
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic crc_cols_type crc_cols();
      crc_cols_type cols;
      for (int i = 0; i < 32; i++) begin
         cols[i] = crc_serial(32'd1 << i, 32'd0);
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COL  = crc_cols();
   localparam logic [31:0]  CRC_ZERO = ~crc_serial(32'd0, CRC_INIT);

   // crc of one word as an xor tree over its bits
   function automatic logic [31:0] word_crc(input logic [31:0] w);
      logic [31:0] c;
      c = CRC_ZERO;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) begin
            c = c ^ CRC_COL[i];
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/rrsc_req_if.sv
// rrsc_req_if: request channel carrying one input word
`timescale 1ns / 1ps

interface rrsc_req_if;
   logic                  valid;
   logic                  ready;
   rrsc_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/rrsc_rsp_if.sv
// rrsc_rsp_if: response channel carrying one result word
`timescale 1ns / 1ps

interface rrsc_rsp_if;
   logic                  valid;
   logic                  ready;
   rrsc_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/rrsc_csr.sv
// rrsc_csr: save interval and delta threshold registers
`timescale 1ns / 1ps

module rrsc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [31:0]                csr_wdata,
   output rrsc_pkg::cfg_type          cfg
);

   rrsc_pkg::cfg_type cfg_ff;
   rrsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rrsc_pkg::CSR_SAVE_INTERVAL:   cfg_in.save_interval   = csr_wdata;
            rrsc_pkg::CSR_DELTA_THRESHOLD: cfg_in.delta_threshold = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.save_interval   <= rrsc_pkg::SAVE_INTERVAL_RST;
         cfg_ff.delta_threshold <= rrsc_pkg::DELTA_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rrsc_in_stage.sv
// rrsc_in_stage: input register for request words
`timescale 1ns / 1ps

module rrsc_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  rrsc_pkg::req_word_type     in_word,
   output rrsc_pkg::stage_type        stage,
   input  logic                       stage_ready
);

   logic                   valid_ff;
   logic                   valid_in;
   rrsc_pkg::req_word_type word_ff;

   assign in_ready = !valid_ff || stage_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule

FILE: rtl/rrsc_core.sv
// rrsc_core: save policy, copy check, policy state and result register
`timescale 1ns / 1ps

module rrsc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  rrsc_pkg::cfg_type          cfg,
   input  rrsc_pkg::stage_type        stage,
   output logic                       stage_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rrsc_pkg::rsp_word_type     rsp_word
);

   logic [31:0]            tick_ff, tick_in;
   logic [31:0]            last_ff, last_in;
   logic [31:0]            saves_ff, saves_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rrsc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                   take;
   logic [31:0]            tick_inc;
   logic [32:0]            diff;
   logic                   delta_hit;
   logic                   go;
   logic [31:0]            sample_crc;
   logic [31:0]            primary_crc;
   logic [31:0]            backup_crc;

   assign stage_ready = !rsp_valid_ff || rsp_ready;
   assign take        = stage.valid && stage_ready;

   assign tick_inc    = (tick_ff == rrsc_pkg::COUNT_MAX) ? tick_ff : tick_ff + 32'd1;
   assign diff        = {1'b0, stage.word.energy_sample} - {1'b0, last_ff};
   assign delta_hit   = !diff[32] && (diff[31:0] >= cfg.delta_threshold);
   assign go          = (tick_inc >= cfg.save_interval) || delta_hit;
   assign sample_crc  = rrsc_pkg::word_crc(stage.word.energy_sample);
   assign primary_crc = rrsc_pkg::word_crc(stage.word.primary_energy);
   assign backup_crc  = rrsc_pkg::word_crc(stage.word.backup_energy);

   always_comb begin
      tick_in     = tick_ff;
      last_in     = last_ff;
      saves_in    = saves_ff;
      rsp_word_in = '0;
      unique case (stage.word.action)
         rrsc_pkg::ACT_TICK: begin
            tick_in = tick_inc;
            if (go) begin
               tick_in                   = '0;
               last_in                   = stage.word.energy_sample;
               saves_in                  = (saves_ff == rrsc_pkg::COUNT_MAX) ?
                                           saves_ff : saves_ff + 32'd1;
               rsp_word_in.save_now      = 1'b1;
               rsp_word_in.record_energy = stage.word.energy_sample;
               rsp_word_in.record_crc    = sample_crc;
            end
         end
         rrsc_pkg::ACT_CHECK: begin
            priority if (primary_crc == stage.word.primary_check) begin
               rsp_word_in.loaded_energy = stage.word.primary_energy;
               rsp_word_in.load_source   = rrsc_pkg::SRC_PRIMARY;
            end else if (backup_crc == stage.word.backup_check) begin
               rsp_word_in.loaded_energy = stage.word.backup_energy;
               rsp_word_in.load_source   = rrsc_pkg::SRC_BACKUP;
            end else begin
               rsp_word_in.loaded_energy = '0;
               rsp_word_in.load_source   = rrsc_pkg::SRC_NONE;
            end
         end
         rrsc_pkg::ACT_CLEAR: begin
            tick_in = '0;
            last_in = '0;
         end
         default: begin
         end
      endcase
      rsp_word_in.write_total = saves_in;
   end

   assign rsp_valid_in = stage_ready ? stage.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         last_ff      <= '0;
         saves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            tick_ff  <= tick_in;
            last_ff  <= last_in;
            saves_ff <= saves_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/redundant_record_save_and_check_top.sv
// redundant_record_save_and_check_top: top level of the redundant record block
`timescale 1ns / 1ps

// each request word gives exactly one response word, via the input register
// and then the result register; one word is taken every cycle while the
// response side keeps up. a tick decides whether to save the sample and gives
// the record with its crc-32, a check returns the first copy whose crc matches
// or none, a clear resets the tick count and last saved value. the rate is set
// by one register stage in front of and one behind the crc and compare logic;
// the user must write configuration only while no word is in flight (unchecked)

module redundant_record_save_and_check_top (
   input  logic        clock,
   input  logic        reset,
   rrsc_req_if.sink    req_chan,
   rrsc_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   rrsc_pkg::cfg_type   cfg;
   rrsc_pkg::stage_type stage;
   logic                stage_ready;

   rrsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rrsc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_word     (req_chan.word),
      .stage       (stage),
      .stage_ready (stage_ready)
   );

   rrsc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_word    (rsp_chan.word)
   );

endmodule

FILE: rtl/rrsc_checker.sv
// rrsc_checker: port-level assertions for the redundant record block
`timescale 1ns / 1ps

module rrsc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rrsc_pkg::rsp_word_type rsp_word
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // a saving tick carries no check result
   a_save_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.save_now |->
         rsp_word.loaded_energy == 32'd0 && rsp_word.load_source == rrsc_pkg::SRC_PRIMARY)
      else $error("save word carries check fields");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_fire ##1 rsp_fire |-> rsp_word.write_total >= $past(rsp_word.write_total))
      else $error("write total went down");

   a_src_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.load_source == rrsc_pkg::SRC_PRIMARY ||
                    rsp_word.load_source == rrsc_pkg::SRC_BACKUP ||
                    rsp_word.load_source == rrsc_pkg::SRC_NONE)
      else $error("load source out of range");

endmodule

bind redundant_record_save_and_check_top rrsc_checker u_rrsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.word)
);
